>>> rtl/gdb_pkg.sv
// Shared types, constants and calendar tables for the date-difference block.
package gdb_pkg;

  localparam int unsigned DAY_W   = 7;
  localparam int unsigned MONTH_W = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAYS_W  = 22;
  localparam int unsigned Q_W     = 8;

  localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
  localparam logic [12:0]        DIV100_MUL   = 13'd5243;
  localparam int unsigned        DIV100_SHIFT = 19;
  localparam logic [8:0]         DAYS_PER_YR  = 9'd365;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 7'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 7'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 7'd12;

  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] dnum;
  } gdb_lane_res_t;

  function automatic logic [DAY_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 7'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 7'd30;
      7'd2:                                       len = leap ? 7'd29 : 7'd28;
      default:                                    len = 7'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] cum_days_f(input logic [MONTH_W-1:0] m);
    logic [8:0] cum;
    case (m)
      7'd1:    cum = 9'd0;
      7'd2:    cum = 9'd31;
      7'd3:    cum = 9'd59;
      7'd4:    cum = 9'd90;
      7'd5:    cum = 9'd120;
      7'd6:    cum = 9'd151;
      7'd7:    cum = 9'd181;
      7'd8:    cum = 9'd212;
      7'd9:    cum = 9'd243;
      7'd10:   cum = 9'd273;
      7'd11:   cum = 9'd304;
      7'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

>>> rtl/gdb_lane.sv
// Date lane: two-stage validity check and day-number computation for one date.
module gdb_lane
  import gdb_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output gdb_lane_res_t      res
);

  logic [YEAR_W-1:0]  yc;
  logic [26:0]        prod_y;
  logic [26:0]        prod_c;

  logic [DAY_W-1:0]   day_r;
  logic [MONTH_W-1:0] month_r;
  logic [YEAR_W-1:0]  year_r;
  logic [YEAR_W-1:0]  yc_r;
  logic [Q_W-1:0]     qy_r;
  logic [Q_W-1:0]     qc_r;

  logic [YEAR_W:0]    qy_x100;
  logic               div4;
  logic               div100;
  logic               leap;
  logic [DAY_W-1:0]   lim;
  logic               ok;
  logic [DAYS_W-1:0]  corr;
  logic [DAYS_W-1:0]  dnum;
  gdb_lane_res_t      res_r;
  gdb_lane_res_t      res_nxt;

  always_comb begin
    if (month <= MONTH_FEB) begin
      yc = (year == '0) ? '0 : year - 14'd1;
    end else begin
      yc = year;
    end
    prod_y = 27'(year) * 27'(DIV100_MUL);
    prod_c = 27'(yc) * 27'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      day_r   <= day;
      month_r <= month;
      year_r  <= year;
      yc_r    <= yc;
      qy_r    <= prod_y[DIV100_SHIFT +: Q_W];
      qc_r    <= prod_c[DIV100_SHIFT +: Q_W];
    end
  end

  always_comb begin
    qy_x100 = {1'b0, qy_r, 6'b0} + {2'b0, qy_r, 5'b0} + {5'b0, qy_r, 2'b0};
    div4    = (year_r[1:0] == 2'b00);
    div100  = (qy_x100 == {1'b0, year_r});
    leap    = div100 ? (qy_r[1:0] == 2'b00) : div4;
    lim     = month_len_f(month_r, leap);
    ok      = (year_r <= YEAR_MAX) && (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC)
              && (day_r != '0) && (day_r <= lim);
    corr    = DAYS_W'(yc_r >> 2) - DAYS_W'(qc_r) + DAYS_W'(qc_r >> 2);
    dnum    = DAYS_W'(DAYS_W'(year_r) * DAYS_W'(DAYS_PER_YR)) + DAYS_W'(day_r)
              + DAYS_W'(cum_days_f(month_r)) + corr;
    res_nxt.ok   = ok;
    res_nxt.dnum = dnum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> rtl/gdb_merge.sv
// Merge stage: combine both lanes into the days-between result register.
module gdb_merge
  import gdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              lanes_valid,
  input  gdb_lane_res_t     res_a,
  input  gdb_lane_res_t     res_b,
  output logic              out_valid,
  output logic [DAYS_W-1:0] out_days_between,
  output logic              out_date_invalid
);

  logic [DAYS_W-1:0] diff;
  logic              valid_r;
  logic [DAYS_W-1:0] days_r;
  logic [DAYS_W-1:0] days_nxt;
  logic              inv_r;
  logic              inv_nxt;

  always_comb begin
    diff = (res_b.dnum > res_a.dnum) ? (res_b.dnum - res_a.dnum)
                                     : (res_a.dnum - res_b.dnum);
    if (res_a.ok && res_b.ok) begin
      inv_nxt  = 1'b0;
      days_nxt = (diff == '0) ? '0 : diff - DAYS_W'(1);
    end else begin
      inv_nxt  = 1'b1;
      days_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= lanes_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days_r <= days_nxt;
      inv_r  <= inv_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_days_between = days_r;
  assign out_date_invalid = inv_r;

endmodule

>>> rtl/gregorian_days_between.sv
// Top level: days strictly between two Gregorian dates, one lane per date.
//
// Input channel: in_valid / in_stall with the six date fields. An item is
// taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_days_between and
// out_date_invalid. A result is taken with out_valid high and out_stall low.
// The accepted item passes two lane stages, each date in its own lane, then
// the merge register, which drives out_valid. Throughput: one item per
// cycle unless stalled; the three stages advance together.
// When the receiver stalls a waiting result, every stage holds and in_stall
// rises in the same cycle; the held result stays on the output.
// Invalid dates give out_date_invalid = 1 and out_days_between = 0.
// Reset (rst_n low, synchronous) drops all items in flight and clears
// out_valid.
module gregorian_days_between
  import gdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [YEAR_W-1:0]  in_second_year,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DAYS_W-1:0]  out_days_between,
  output logic               out_date_invalid
);

  logic          en;
  logic          s1_valid_r;
  logic          s2_valid_r;
  gdb_lane_res_t res_a;
  gdb_lane_res_t res_b;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  gdb_lane u_lane_a (
    .clk   (clk),
    .en    (en),
    .day   (in_first_day),
    .month (in_first_month),
    .year  (in_first_year),
    .res   (res_a)
  );

  gdb_lane u_lane_b (
    .clk   (clk),
    .en    (en),
    .day   (in_second_day),
    .month (in_second_month),
    .year  (in_second_year),
    .res   (res_b)
  );

  gdb_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .lanes_valid      (s2_valid_r),
    .res_a            (res_a),
    .res_b            (res_b),
    .out_valid        (out_valid),
    .out_days_between (out_days_between),
    .out_date_invalid (out_date_invalid)
  );

endmodule

>>> rtl/gdb_checker.sv
// Port-level checker for the date-difference block, with its bind.
module gdb_checker
  import gdb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DAYS_W-1:0] out_days_between,
  input logic              out_date_invalid
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled item dropped");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_date_invalid) |-> (out_days_between == '0))
    else $error("invalid item with nonzero day count");

  a_days_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_days_between <= DAYS_W'(3652500)))
    else $error("day count out of range");

endmodule

bind gregorian_days_between gdb_checker u_gdb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_days_between (out_days_between),
  .out_date_invalid (out_date_invalid)
);

>>> verif/gdb_span_checker.sv
// Checker: watches both channels, predicts day spans and compares results.
`timescale 1ns / 100ps

module gdb_span_checker
  import gdb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [YEAR_W-1:0]  in_second_year,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DAYS_W-1:0]  out_days_between,
  input  logic               out_date_invalid,
  output int unsigned        fail_count,
  output int unsigned        pending,
  output int unsigned        checked
);

  localparam int unsigned FEB_LEAP_LEN = 29;
  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic              invalid;
  } span_t;

  span_t span_q[$];

  function automatic bit date_real(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
    int unsigned lim;
    if (y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC || d == 0) return 1'b0;
    lim = MONTH_DAYS[m-1];
    if (m == MONTH_FEB && ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))))
      lim = FEB_LEAP_LEN;
    return d <= lim;
  endfunction

  function automatic int unsigned day_count(input int unsigned d, input int unsigned m,
                                            input int unsigned y);
    int unsigned total;
    int unsigned ly;
    total = y * DAYS_PER_YR + d;
    for (int i = 0; i + 1 < m; i++) total += MONTH_DAYS[i];
    ly = y;
    if (m <= MONTH_FEB) begin
      if (y == 0) return total;
      ly = y - 1;
    end
    return total + ly / 4 - ly / 100 + ly / 400;
  endfunction

  function automatic span_t predict_span();
    span_t sp;
    int unsigned t1;
    int unsigned t2;
    int unsigned diff;
    sp = '0;
    if (!date_real(in_first_day, in_first_month, in_first_year) ||
        !date_real(in_second_day, in_second_month, in_second_year)) begin
      sp.invalid = 1'b1;
      return sp;
    end
    t1 = day_count(in_first_day, in_first_month, in_first_year);
    t2 = day_count(in_second_day, in_second_month, in_second_year);
    diff = (t2 > t1) ? t2 - t1 : t1 - t2;
    sp.days = DAYS_W'((diff > 0) ? diff - 1 : 0);
    return sp;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    span_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) span_q.push_back(predict_span());
      if (out_valid && !out_stall) begin
        checked++;
        if (span_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected: days %0d invalid %0b",
                   $time, out_days_between, out_date_invalid);
        end else begin
          want = span_q.pop_front();
          if (out_days_between !== want.days) begin
            fail_count++;
            $display("%0t: days_between expected %0d actual %0d",
                     $time, want.days, out_days_between);
          end
          if (out_date_invalid !== want.invalid) begin
            fail_count++;
            $display("%0t: date_invalid expected %0b actual %0b",
                     $time, want.invalid, out_date_invalid);
          end
        end
      end
      pending = span_q.size();
    end
  end

endmodule

>>> verif/gregorian_days_between_tb.sv
// Testbench top: drives date pairs through the block and reports the verdict.
`timescale 1ns / 100ps

module gregorian_days_between_tb;
  import gdb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DAY_TOP     = (1 << DAY_W) - 1;
  localparam int unsigned MONTH_TOP   = (1 << MONTH_W) - 1;
  localparam int unsigned YEAR_TOP    = (1 << YEAR_W) - 1;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DAY_W-1:0]   in_first_day;
  logic [MONTH_W-1:0] in_first_month;
  logic [YEAR_W-1:0]  in_first_year;
  logic [DAY_W-1:0]   in_second_day;
  logic [MONTH_W-1:0] in_second_month;
  logic [YEAR_W-1:0]  in_second_year;
  logic               out_valid;
  logic               out_stall;
  logic [DAYS_W-1:0]  out_days_between;
  logic               out_date_invalid;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned pairs_sent;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  bit          hold_go;

  gregorian_days_between dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_day     (in_first_day),
    .in_first_month   (in_first_month),
    .in_first_year    (in_first_year),
    .in_second_day    (in_second_day),
    .in_second_month  (in_second_month),
    .in_second_year   (in_second_year),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_days_between (out_days_between),
    .out_date_invalid (out_date_invalid)
  );

  gdb_span_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_day     (in_first_day),
    .in_first_month   (in_first_month),
    .in_first_year    (in_first_year),
    .in_second_day    (in_second_day),
    .in_second_month  (in_second_month),
    .in_second_year   (in_second_year),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_days_between (out_days_between),
    .out_date_invalid (out_date_invalid),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("gregorian_days_between test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t dt;
    dt.day = DAY_W'(d);
    dt.month = MONTH_W'(m);
    dt.year = YEAR_W'(y);
    return dt;
  endfunction

  function automatic date_t random_date();
    date_t dt;
    int unsigned kind;
    int unsigned len;
    bit leap;
    kind = $urandom_range(99);
    dt.year = YEAR_W'((kind < 15) ? $urandom_range(3) : $urandom_range(YEAR_MAX));
    dt.month = MONTH_W'($urandom_range(MONTH_DEC, MONTH_JAN));
    leap = (dt.year % 400 == 0) || ((dt.year % 100 != 0) && (dt.year % 4 == 0));
    len = month_len_f(dt.month, leap);
    dt.day = DAY_W'($urandom_range(len, 1));
    if (kind >= 90) begin
      if (kind < 92)
        dt.month = MONTH_W'($urandom_range(1) ? 0 : $urandom_range(MONTH_TOP, 13));
      else if (kind < 94)
        dt.day = DAY_W'($urandom_range(1) ? 0 : $urandom_range(DAY_TOP, len + 1));
      else if (kind < 96)
        dt.year = YEAR_W'($urandom_range(YEAR_TOP, YEAR_MAX + 1));
      else begin
        dt.day = DAY_W'($urandom_range(DAY_TOP));
        dt.month = MONTH_W'($urandom_range(MONTH_TOP));
        dt.year = YEAR_W'($urandom_range(YEAR_TOP));
      end
    end
    return dt;
  endfunction

  task automatic offer_pair(input date_t a, input date_t b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_first_day    <= a.day;
    in_first_month  <= a.month;
    in_first_year   <= a.year;
    in_second_day   <= b.day;
    in_second_month <= b.month;
    in_second_year  <= b.year;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall,
                           input int unsigned count, input bit with_hold);
    date_t a;
    date_t b;
    int unsigned pick;
    gap_pct = gap;
    stall_pct = stall;
    if (with_hold) hold_go = 1'b1;
    repeat (count) begin
      a = random_date();
      b = random_date();
      pick = $urandom_range(9);
      if (pick == 0) b = a;
      else if (pick == 1) begin
        b = a;
        b.day = DAY_W'(a.day + 1);
      end
      offer_pair(a, b);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_first_day = '0;
    in_first_month = '0;
    in_first_year = '0;
    in_second_day = '0;
    in_second_month = '0;
    in_second_year = '0;
    gap_pct = 0;
    stall_pct = 0;
    pairs_sent = 0;
    hold_go = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_pair(mk_date(1, 1, 0), mk_date(1, 1, 0));
    offer_pair(mk_date(1, 1, 0), mk_date(2, 1, 0));
    offer_pair(mk_date(31, 12, 9999), mk_date(1, 1, 0));
    offer_pair(mk_date(1, 1, 0), mk_date(31, 12, 9999));
    offer_pair(mk_date(29, 2, 2000), mk_date(1, 3, 2000));
    offer_pair(mk_date(29, 2, 1900), mk_date(1, 3, 1900));
    offer_pair(mk_date(29, 2, 2024), mk_date(28, 2, 2023));
    offer_pair(mk_date(29, 2, 2023), mk_date(1, 1, 2023));
    offer_pair(mk_date(15, 2, 0), mk_date(1, 3, 0));
    offer_pair(mk_date(29, 2, 0), mk_date(31, 1, 0));
    offer_pair(mk_date(28, 2, 2100), mk_date(1, 3, 2100));
    offer_pair(mk_date(1, 0, 2000), mk_date(1, 1, 2000));
    offer_pair(mk_date(1, 1, 2000), mk_date(1, 13, 2000));
    offer_pair(mk_date(1, MONTH_TOP, 2000), mk_date(1, 1, 2000));
    offer_pair(mk_date(0, 5, 2000), mk_date(1, 5, 2000));
    offer_pair(mk_date(1, 5, 2000), mk_date(DAY_TOP, 5, 2000));
    offer_pair(mk_date(32, 1, 2000), mk_date(1, 1, 2000));
    offer_pair(mk_date(31, 4, 2000), mk_date(30, 4, 2000));
    offer_pair(mk_date(1, 1, 10000), mk_date(1, 1, 9999));
    offer_pair(mk_date(1, 1, 9999), mk_date(1, 1, YEAR_TOP));
    offer_pair(mk_date(DAY_TOP, MONTH_TOP, YEAR_TOP), mk_date(DAY_TOP, MONTH_TOP, YEAR_TOP));
    offer_pair(mk_date(31, 12, 1999), mk_date(1, 1, 2000));
    drain();

    run_phase(9, 81, 140, 1'b0);
    run_phase(81, 9, 140, 1'b0);
    run_phase(0, 0, 150, 1'b1);

    repeat (10) @(posedge clk);
    $display("Ran %0d date pairs, %0d results checked: edge dates, invalid fields, leap years,",
             pairs_sent, checked);
    $display("three idle patterns and a long output hold-off that backs up the input.");
    if (fail_count == 0 && pending == 0) begin
      $display("gregorian_days_between test passed");
    end else begin
      $display("gregorian_days_between test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gdb_pkg.sv
rtl/gdb_lane.sv
rtl/gdb_merge.sv
rtl/gregorian_days_between.sv
rtl/gdb_checker.sv
verif/gdb_span_checker.sv
verif/gregorian_days_between_tb.sv
